@@ src/crc8fr_pkg.sv @@
package crc8fr_pkg;

    localparam int PAYLOAD_DEPTH_DEF = 256;
    localparam int BYTE_W            = 8;
    localparam int LANES             = 4;
    localparam int WORD_W            = BYTE_W * LANES;
    localparam int CNT_W             = 3;   // 1..4 valid bytes
    localparam int WORD_IDX_W        = 6;   // up to 64 words for a 255-byte payload

    localparam logic [BYTE_W-1:0] START_BYTE = 8'h7E;
    localparam logic [BYTE_W-1:0] END_BYTE   = 8'h7F;
    localparam logic [BYTE_W-1:0] CRC_POLY   = 8'h07;
    localparam logic [BYTE_W-1:0] CRC_INIT   = 8'h00;
    localparam logic [BYTE_W-1:0] ZERO_LEN   = 8'h00;

    typedef struct packed {
        logic load_len;
        logic store_byte;
        logic load_rx_crc;
        logic drain_start;
        logic read_word;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_start;
        logic len_zero;
        logic is_end;
        logic last_payload;
        logic crc_match;
        logic last_word;
        logic out_free;
    } t_dp_status;

    // CRC-8, MSB first, no reflection
    function automatic logic [BYTE_W-1:0] crc_update(input logic [BYTE_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ src/crc8fr_if.sv @@
interface crc8fr_byte_if;
    logic                          valid;
    logic                          ready;
    logic [crc8fr_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crc8fr_word_if;
    logic                          valid;
    logic                          ready;
    logic [crc8fr_pkg::WORD_W-1:0] data_word;
    logic [crc8fr_pkg::CNT_W-1:0]  valid_bytes;
    logic [crc8fr_pkg::BYTE_W-1:0] frame_length;
    logic                          last_word;

    modport source (output valid, output data_word, output valid_bytes,
                    output frame_length, output last_word, input ready);
    modport sink   (input valid, input data_word, input valid_bytes,
                    input frame_length, input last_word, output ready);
endinterface

@@ src/crc8fr_ctrl.sv @@
module crc8fr_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rx_valid,
    output logic                   o_rx_ready,
    input  crc8fr_pkg::t_dp_status i_status,
    output crc8fr_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_HUNT     = 7'b0000001,
        S_LENGTH   = 7'b0000010,
        S_PAYLOAD  = 7'b0000100,
        S_CHECK    = 7'b0001000,
        S_CLOSE    = 7'b0010000,
        S_DRAIN_RD = 7'b0100000,
        S_DRAIN_LD = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   w_acc;

    assign o_rx_ready = r_state inside {S_HUNT, S_LENGTH, S_PAYLOAD, S_CHECK, S_CLOSE};
    assign w_acc      = i_rx_valid && o_rx_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_HUNT: begin
                if (w_acc && i_status.is_start) begin
                    n_state = S_LENGTH;
                end
            end
            S_LENGTH: begin
                if (w_acc) begin
                    if (i_status.len_zero) begin
                        n_state = S_HUNT;
                    end else begin
                        o_cmd.load_len = 1'b1;
                        n_state        = S_PAYLOAD;
                    end
                end
            end
            S_PAYLOAD: begin
                if (w_acc) begin
                    o_cmd.store_byte = 1'b1;
                    if (i_status.last_payload) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (w_acc) begin
                    o_cmd.load_rx_crc = 1'b1;
                    n_state           = S_CLOSE;
                end
            end
            S_CLOSE: begin
                if (w_acc) begin
                    if (i_status.is_end && i_status.crc_match) begin
                        o_cmd.drain_start = 1'b1;
                        n_state           = S_DRAIN_RD;
                    end else begin
                        n_state = S_HUNT;
                    end
                end
            end
            S_DRAIN_RD: begin
                if (i_status.out_free) begin
                    o_cmd.read_word = 1'b1;
                    n_state         = S_DRAIN_LD;
                end
            end
            S_DRAIN_LD: begin
                o_cmd.load_out = 1'b1;
                n_state        = i_status.last_word ? S_HUNT : S_DRAIN_RD;
            end
            default: begin
                n_state = S_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ src/crc8fr_dp.sv @@
module crc8fr_dp #(
    parameter int PAYLOAD_DEPTH = crc8fr_pkg::PAYLOAD_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  crc8fr_pkg::t_dp_cmd           i_cmd,
    input  logic [crc8fr_pkg::BYTE_W-1:0] i_rx_byte,
    output crc8fr_pkg::t_dp_status        o_status,
    crc8fr_word_if.source                 o_tx
);

    localparam int BW      = crc8fr_pkg::BYTE_W;
    localparam int LN      = crc8fr_pkg::LANES;
    localparam int WIW     = crc8fr_pkg::WORD_IDX_W;
    localparam int CW      = crc8fr_pkg::CNT_W;
    localparam int WORDS   = PAYLOAD_DEPTH / LN;
    localparam int WORD_AW = $clog2(WORDS);

    // payload store, one byte lane per write
    logic [LN-1:0][BW-1:0] r_mem [WORDS];

    logic [BW-1:0]         r_len, r_pos, r_crc, r_rx_crc;
    logic [WIW-1:0]        r_widx;
    logic [LN-1:0][BW-1:0] r_rd_data;

    logic                  r_out_valid;
    logic [LN-1:0][BW-1:0] r_out_word;
    logic [CW-1:0]         r_out_cnt;
    logic [BW-1:0]         r_out_len;
    logic                  r_out_last;

    logic [BW-1:0]         w_rem;
    logic                  w_last;
    logic [CW-1:0]         w_cnt;
    logic [LN-1:0][BW-1:0] w_word;
    logic [WORD_AW-1:0]    w_wr_addr, w_rd_addr;

    assign w_wr_addr = WORD_AW'(r_pos[BW-1:2]);
    assign w_rd_addr = WORD_AW'(r_widx);

    // bytes left from the current word on
    assign w_rem  = r_len - {r_widx, 2'b00};
    assign w_last = (w_rem <= BW'(LN));
    assign w_cnt  = w_last ? w_rem[CW-1:0] : CW'(LN);

    always_comb begin
        for (int i = 0; i < LN; i++) begin
            w_word[i] = (CW'(i) < w_cnt) ? r_rd_data[i] : '0;
        end
    end

    always_comb begin
        o_status.is_start     = (i_rx_byte == crc8fr_pkg::START_BYTE);
        o_status.len_zero     = (i_rx_byte == crc8fr_pkg::ZERO_LEN);
        o_status.is_end       = (i_rx_byte == crc8fr_pkg::END_BYTE);
        o_status.last_payload = ({1'b0, r_pos} + 9'd1) == {1'b0, r_len};
        o_status.crc_match    = (r_crc == r_rx_crc);
        o_status.last_word    = w_last;
        o_status.out_free     = !r_out_valid || o_tx.ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_byte) begin
            r_mem[w_wr_addr][r_pos[1:0]] <= i_rx_byte;
        end
        if (i_cmd.read_word) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_len) begin
            r_len <= i_rx_byte;
            r_pos <= '0;
            r_crc <= crc8fr_pkg::crc_update(crc8fr_pkg::CRC_INIT, i_rx_byte);
        end else if (i_cmd.store_byte) begin
            r_pos <= r_pos + 1'b1;
            r_crc <= crc8fr_pkg::crc_update(r_crc, i_rx_byte);
        end
        if (i_cmd.load_rx_crc) begin
            r_rx_crc <= i_rx_byte;
        end
        if (i_cmd.drain_start) begin
            r_widx <= '0;
        end else if (i_cmd.load_out) begin
            r_widx <= r_widx + 1'b1;
        end
        if (i_cmd.load_out) begin
            r_out_word <= w_word;
            r_out_cnt  <= w_cnt;
            r_out_len  <= r_len;
            r_out_last <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_tx.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_tx.valid        = r_out_valid;
    assign o_tx.data_word    = r_out_word;
    assign o_tx.valid_bytes  = r_out_cnt;
    assign o_tx.frame_length = r_out_len;
    assign o_tx.last_word    = r_out_last;

endmodule

@@ src/crc8_frame_receiver.sv @@
// Length-prefixed frame receiver with CRC-8 check (poly 0x07, init 0, MSB first).
// i_rx carries received bytes, one per transfer. Frame: 0x7E, length (1..255),
// payload, CRC byte, 0x7F. CRC covers length and payload bytes.
// o_tx carries the payload of a good frame as 32-bit words, earliest byte in
// bits 7:0, with valid_bytes, frame_length and last_word on each transfer.
// Bad end byte, CRC mismatch or zero length drop the frame without output.
// Input side: one byte per cycle while the parser is open for bytes.
// After the end-byte transfer the parser drains the payload store, which
// has one read port: each word passes through a read state and then a
// load state into the output register, ceil(length/4) words in all;
// i_rx.ready is low meanwhile.
// The output register holds a word until it is taken; a stalled receiver
// holds the drain in its read state. After the last word is loaded, bytes
// of the next frame are taken while that word still waits.
// Reset (synchronous, active low) returns the parser to start-byte hunt and
// empties the output register. The payload store is not cleared.
module crc8_frame_receiver #(
    parameter int PAYLOAD_DEPTH = crc8fr_pkg::PAYLOAD_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    crc8fr_byte_if.sink i_rx,
    crc8fr_word_if.source o_tx
);

    crc8fr_pkg::t_dp_cmd    w_cmd;
    crc8fr_pkg::t_dp_status w_status;
    logic                   w_rx_ready;

    assign i_rx.ready = w_rx_ready;

    // parse phase and drain sequencing
    crc8fr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx.valid),
        .o_rx_ready (w_rx_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // length, position, CRC, payload store and output register
    crc8fr_dp #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_rx_byte (i_rx.rx_byte),
        .o_status  (w_status),
        .o_tx      (o_tx)
    );

endmodule
